// ----- design/json_string_unescape_defines.svh -----
// assertion macros for the json string unescaper checker
// expects clk and rst_n in the scope where they are used
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// checked only while out of reset
`define JSU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define JSU_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/jsu_pkg.sv -----
// shared types, codes and the utf-8 encoder of the json string unescaper
// no dependencies
package jsu_pkg;

  localparam int JSU_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    JSU_ST_DATA  = 2'd0,
    JSU_ST_CLOSE = 2'd1,
    JSU_ST_ERROR = 2'd2
  } jsu_status_t;

  typedef enum logic [2:0] {
    JSU_ERR_NONE         = 3'd0,
    JSU_ERR_NO_QUOTE     = 3'd1,
    JSU_ERR_BAD_ESCAPE   = 3'd2,
    JSU_ERR_BAD_HEX      = 3'd3,
    JSU_ERR_BAD_PAIR     = 3'd4,
    JSU_ERR_CONTROL      = 3'd5,
    JSU_ERR_UNTERMINATED = 3'd6
  } jsu_err_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      ndata;
    logic            has_tail;
    jsu_status_t     tail_status;
    jsu_err_t        tail_code;
  } jsu_desc_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n;
  } jsu_utf8_t;

  function automatic jsu_utf8_t jsu_utf8_encode(input logic [20:0] cp);
    jsu_utf8_t e;
    e.data = '0;
    if (cp <= 21'h7f) begin
      e.data[0] = cp[7:0];
      e.n = 3'd1;
    end else if (cp <= 21'h7ff) begin
      e.data[0] = {3'b110, cp[10:6]};
      e.data[1] = {2'b10, cp[5:0]};
      e.n = 3'd2;
    end else if (cp <= 21'hffff) begin
      e.data[0] = {4'b1110, cp[15:12]};
      e.data[1] = {2'b10, cp[11:6]};
      e.data[2] = {2'b10, cp[5:0]};
      e.n = 3'd3;
    end else begin
      e.data[0] = {5'b11110, cp[20:18]};
      e.data[1] = {2'b10, cp[17:12]};
      e.data[2] = {2'b10, cp[11:6]};
      e.data[3] = {2'b10, cp[5:0]};
      e.n = 3'd4;
    end
    return e;
  endfunction

endpackage

// ----- design/jsu_stream_if.sv -----
// valid/ready channel interfaces for the input bytes and the results
// no dependencies
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;
  modport source (output valid, in_byte, is_last, input ready);
  modport sink (input valid, in_byte, is_last, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic [2:0] error_code;
  logic       last_of_run;
  modport source (output valid, out_byte, status, error_code, last_of_run, input ready);
  modport sink (input valid, out_byte, status, error_code, last_of_run, output ready);
endinterface

// ----- design/jsu_front.sv -----
// front end: accepts bytes, runs the string parser and builds one result descriptor
// per byte; depends on jsu_pkg and jsu_in_if
module jsu_front import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  input  logic      q_full,
  output logic      push,
  output jsu_desc_t push_desc
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX     = 3'd3,
    PH_HELD    = 3'd4,
    PH_HELD_BS = 3'd5,
    PH_HEX2    = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [9:0]  held_r, held_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] accum_sh;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic        do_body, do_esc;
  logic        cp_en, ex_en, tail_en;
  logic [20:0] cp;
  logic [7:0]  ex;
  jsu_status_t tail_status;
  jsu_err_t    tail_code;
  jsu_utf8_t   enc;
  jsu_desc_t   desc;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !q_full;
  assign b             = in_chan.in_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b >= "0" && b <= "9") begin
      hex_val = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      hex_val = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      hex_val = 4'(b - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign accum_sh = {accum_r[11:0], hex_val};

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = b;
    case (b)
      "\"", "\\", "/": esc_val = b;
      "b":             esc_val = 8'h08;
      "f":             esc_val = 8'h0c;
      "n":             esc_val = 8'h0a;
      "r":             esc_val = 8'h0d;
      "t":             esc_val = 8'h09;
      default:         esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    count_nxt   = count_r;
    held_nxt    = held_r;
    do_body     = 1'b0;
    do_esc      = 1'b0;
    cp_en       = 1'b0;
    cp          = '0;
    ex_en       = 1'b0;
    ex          = '0;
    tail_en     = 1'b0;
    tail_status = JSU_ST_ERROR;
    tail_code   = JSU_ERR_NONE;

    case (phase_r)
      PH_BODY: do_body = 1'b1;
      PH_ESC:  do_esc = 1'b1;
      PH_HEX: begin
        if (!hex_ok) begin
          tail_en   = 1'b1;
          tail_code = JSU_ERR_BAD_HEX;
          phase_nxt = PH_IDLE;
        end else begin
          accum_nxt = accum_sh;
          count_nxt = count_r + 2'd1;
          if (count_r == 2'd3) begin
            if (accum_sh[15:10] == 6'b110110) begin
              held_nxt  = accum_sh[9:0];
              phase_nxt = PH_HELD;
            end else begin
              cp_en     = 1'b1;
              cp        = {5'd0, accum_sh};
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_HELD: begin
        if (b == "\\") begin
          phase_nxt = PH_HELD_BS;
        end else begin
          cp_en     = 1'b1;
          cp        = {5'd0, 6'b110110, held_r};
          phase_nxt = PH_BODY;
          do_body   = 1'b1;
        end
      end
      PH_HELD_BS: begin
        if (b == "u") begin
          phase_nxt = PH_HEX2;
          accum_nxt = '0;
          count_nxt = '0;
        end else begin
          cp_en     = 1'b1;
          cp        = {5'd0, 6'b110110, held_r};
          phase_nxt = PH_ESC;
          do_esc    = 1'b1;
        end
      end
      PH_HEX2: begin
        if (!hex_ok) begin
          tail_en   = 1'b1;
          tail_code = JSU_ERR_BAD_HEX;
          phase_nxt = PH_IDLE;
        end else begin
          accum_nxt = accum_sh;
          count_nxt = count_r + 2'd1;
          if (count_r == 2'd3) begin
            if (accum_sh[15:10] != 6'b110111) begin
              tail_en   = 1'b1;
              tail_code = JSU_ERR_BAD_PAIR;
              phase_nxt = PH_IDLE;
            end else begin
              cp_en     = 1'b1;
              cp        = 21'h10000 + {1'b0, held_r, accum_sh[9:0]};
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      default: begin
        if (b == "\"") begin
          phase_nxt = PH_BODY;
        end else begin
          tail_en   = 1'b1;
          tail_code = JSU_ERR_NO_QUOTE;
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    if (do_body) begin
      if (b == "\"") begin
        tail_en     = 1'b1;
        tail_status = JSU_ST_CLOSE;
        phase_nxt   = PH_IDLE;
      end else if (b == "\\") begin
        phase_nxt = PH_ESC;
      end else if (b < 8'h20) begin
        tail_en   = 1'b1;
        tail_code = JSU_ERR_CONTROL;
        phase_nxt = PH_IDLE;
      end else begin
        ex_en = 1'b1;
        ex    = b;
      end
    end

    if (do_esc) begin
      if (esc_ok) begin
        ex_en     = 1'b1;
        ex        = esc_val;
        phase_nxt = PH_BODY;
      end else if (b == "u") begin
        phase_nxt = PH_HEX;
        accum_nxt = '0;
        count_nxt = '0;
      end else begin
        tail_en   = 1'b1;
        tail_code = JSU_ERR_BAD_ESCAPE;
        phase_nxt = PH_IDLE;
      end
    end

    // end of message inside the string
    if (in_chan.is_last && phase_nxt != PH_IDLE) begin
      if (phase_nxt == PH_HELD || phase_nxt == PH_HELD_BS) begin
        cp_en = 1'b1;
        cp    = {5'd0, 6'b110110, held_nxt};
      end
      tail_en   = 1'b1;
      tail_code = JSU_ERR_UNTERMINATED;
      phase_nxt = PH_IDLE;
    end

    if (phase_nxt == PH_IDLE) begin
      accum_nxt = '0;
      count_nxt = '0;
      held_nxt  = '0;
    end
  end

  assign enc = jsu_utf8_encode(cp);

  always_comb begin
    desc.data        = cp_en ? enc.data : '0;
    desc.ndata       = cp_en ? enc.n : 3'd0;
    desc.has_tail    = tail_en;
    desc.tail_status = tail_status;
    desc.tail_code   = tail_code;
    if (ex_en) begin
      desc.data[desc.ndata[1:0]] = ex;
      desc.ndata                 = desc.ndata + 3'd1;
    end
  end

  assign push      = accept && (desc.ndata != 3'd0 || desc.has_tail);
  assign push_desc = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= '0;
      count_r <= '0;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- design/jsu_queue.sv -----
// descriptor queue between the parser front end and the result sequencer
// depends on jsu_pkg
module jsu_queue import jsu_pkg::*; #(
  parameter int DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  jsu_desc_t push_desc,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output jsu_desc_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_desc_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ----- design/jsu_back.sv -----
// back end: walks the head descriptor one result per cycle into the output register
// while the output is not stalled; depends on jsu_pkg and jsu_out_if
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  jsu_desc_t head,
  output logic      pop,
  jsu_out_if.source out_chan
);

  logic [2:0]  idx_r;
  logic [2:0]  total;
  logic        load;
  logic        is_last;
  logic [7:0]  byte_sel;
  jsu_status_t st_sel;
  jsu_err_t    code_sel;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  jsu_status_t status_r;
  jsu_err_t    code_r;
  logic        last_r;

  assign total   = head.ndata + {2'b00, head.has_tail};
  assign load    = (!out_valid_r || out_chan.ready) && !q_empty;
  assign is_last = (idx_r == total - 3'd1);
  assign pop     = load && is_last;

  always_comb begin
    if (idx_r < head.ndata) begin
      byte_sel = head.data[idx_r[1:0]];
      st_sel   = JSU_ST_DATA;
      code_sel = JSU_ERR_NONE;
    end else begin
      byte_sel = '0;
      st_sel   = head.tail_status;
      code_sel = head.tail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= is_last ? 3'd0 : idx_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_sel;
      status_r   <= st_sel;
      code_r     <= code_sel;
      last_r     <= is_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.status      = status_r;
  assign out_chan.error_code  = code_r;
  assign out_chan.last_of_run = last_r;

endmodule

// ----- design/json_string_unescape.sv -----
// top level of the json string unescaper: parser front end, descriptor queue, result sequencer
// depends on jsu_pkg, jsu_stream_if, jsu_front, jsu_queue and jsu_back
// The block takes one byte of a message per cycle and decodes one JSON string
// literal, opening quote first, into UTF-8 bytes, followed by a close or an error
// result. Each accepted byte that causes results leaves a descriptor of its one to
// five results in a queue of QUEUE_DEPTH entries; the result sequencer sends one
// result per cycle through an output register while the output is not stalled. A
// byte is thus accepted every cycle while the queue has room, and a byte that yields
// n results leaves n transactions on the output side (a surrogate pair gives four
// bytes, a lone surrogate three). The first result of a byte goes through the queue
// memory and then the output register. No clearing pass is needed after reset.
module json_string_unescape import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);

  logic      q_full, q_empty, push, pop;
  jsu_desc_t push_desc, head;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ----- design/jsu_checker.sv -----
// port level checks of the json string unescaper and their bind to the top level
// depends on json_string_unescape_defines.svh
`include "json_string_unescape_defines.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic [2:0] error_code,
  input logic       last_of_run
);

  `JSU_ASSERT_ANY(a_reset_clears_out, !rst_n |=> !out_valid, "result valid right after reset")
  `JSU_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status) && $stable(error_code) && $stable(last_of_run), "stalled result changed")
  `JSU_ASSERT_RST(a_fields_consistent, out_valid |-> (status == 2'd0 && error_code == 3'd0) || (status == 2'd1 && error_code == 3'd0 && out_byte == 8'd0) || (status == 2'd2 && error_code != 3'd0 && error_code <= 3'd6 && out_byte == 8'd0), "inconsistent result fields")
  `JSU_ASSERT_RST(a_end_is_last, out_valid && status != 2'd0 |-> last_of_run, "close or error not last of its run")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_byte    (out_chan.out_byte),
  .status      (out_chan.status),
  .error_code  (out_chan.error_code),
  .last_of_run (out_chan.last_of_run)
);

// ----- tb/jsu_result_checker.sv -----
// result checker for the json string unescaper: decodes every accepted input byte on
// its own and compares each output transaction with the oldest predicted result
// depends on jsu_pkg and the channel interfaces in jsu_stream_if
module jsu_result_checker import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jsu_in_if    in_mon,
  jsu_out_if   out_mon,
  input  logic drained,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TEXT,
    SCAN_ESC,
    SCAN_HEX,
    SCAN_HELD,
    SCAN_HELD_BS,
    SCAN_LOW_HEX
  } scan_t;

  typedef struct packed {
    logic [7:0]  data;
    jsu_status_t status;
    jsu_err_t    code;
    logic        run_end;
  } unesc_result_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam int         MAX_RUN   = 5;

  scan_t         scan;
  logic [15:0]   hex_acc;
  logic [1:0]    hex_n;
  logic [15:0]   high_half;
  unesc_result_t run_q[$];
  unesc_result_t utf8_expect_q[$];
  int            results_seen;
  bit            swept;

  task automatic report(input string msg);
    errors++;
    if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void put_result(logic [7:0] b, jsu_status_t st, jsu_err_t code);
    unesc_result_t r;
    r.data    = b;
    r.status  = st;
    r.code    = code;
    r.run_end = 1'b0;
    if (run_q.size() < MAX_RUN) run_q.insert(run_q.size(), r);
  endfunction

  function automatic void go_idle();
    scan      = SCAN_IDLE;
    hex_acc   = '0;
    hex_n     = '0;
    high_half = '0;
  endfunction

  function automatic void abort_string(jsu_err_t code);
    put_result(8'h00, JSU_ST_ERROR, code);
    go_idle();
  endfunction

  function automatic void put_code_point(logic [20:0] cp);
    if (cp <= 21'h7f) begin
      put_result(cp[7:0], JSU_ST_DATA, JSU_ERR_NONE);
    end else if (cp <= 21'h7ff) begin
      put_result(8'hc0 | 8'(cp >> 6), JSU_ST_DATA, JSU_ERR_NONE);
      put_result(8'h80 | 8'(cp & 21'h3f), JSU_ST_DATA, JSU_ERR_NONE);
    end else if (cp <= 21'hffff) begin
      put_result(8'he0 | 8'(cp >> 12), JSU_ST_DATA, JSU_ERR_NONE);
      put_result(8'h80 | 8'((cp >> 6) & 21'h3f), JSU_ST_DATA, JSU_ERR_NONE);
      put_result(8'h80 | 8'(cp & 21'h3f), JSU_ST_DATA, JSU_ERR_NONE);
    end else begin
      put_result(8'hf0 | 8'(cp >> 18), JSU_ST_DATA, JSU_ERR_NONE);
      put_result(8'h80 | 8'((cp >> 12) & 21'h3f), JSU_ST_DATA, JSU_ERR_NONE);
      put_result(8'h80 | 8'((cp >> 6) & 21'h3f), JSU_ST_DATA, JSU_ERR_NONE);
      put_result(8'h80 | 8'(cp & 21'h3f), JSU_ST_DATA, JSU_ERR_NONE);
    end
  endfunction

  function automatic void text_byte(logic [7:0] b);
    if (b == CH_QUOTE) begin
      put_result(8'h00, JSU_ST_CLOSE, JSU_ERR_NONE);
      go_idle();
    end else if (b == CH_BSLASH) begin
      scan = SCAN_ESC;
    end else if (b < 8'h20) begin
      abort_string(JSU_ERR_CONTROL);
    end else begin
      put_result(b, JSU_ST_DATA, JSU_ERR_NONE);
    end
  endfunction

  function automatic void escape_byte(logic [7:0] b);
    logic [7:0] v;
    case (b)
      CH_QUOTE, CH_BSLASH, "/": v = b;
      "b": v = 8'h08;
      "f": v = 8'h0c;
      "n": v = 8'h0a;
      "r": v = 8'h0d;
      "t": v = 8'h09;
      "u": begin
        scan    = SCAN_HEX;
        hex_acc = '0;
        hex_n   = '0;
        return;
      end
      default: begin
        abort_string(JSU_ERR_BAD_ESCAPE);
        return;
      end
    endcase
    put_result(v, JSU_ST_DATA, JSU_ERR_NONE);
    scan = SCAN_TEXT;
  endfunction

  function automatic int nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // true once the fourth digit is in
  function automatic bit hex_step(logic [7:0] b);
    int d;
    d = nibble(b);
    if (d < 0) begin
      abort_string(JSU_ERR_BAD_HEX);
      return 1'b0;
    end
    hex_acc = {hex_acc[11:0], 4'(d)};
    if (hex_n == 2'd3) begin
      hex_n = '0;
      return 1'b1;
    end
    hex_n = hex_n + 2'd1;
    return 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic is_end);
    logic [20:0] cp;
    run_q.delete();
    case (scan)
      SCAN_TEXT: text_byte(b);
      SCAN_ESC: escape_byte(b);
      SCAN_HEX: if (hex_step(b)) begin
        if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
          high_half = hex_acc;
          scan      = SCAN_HELD;
        end else begin
          put_code_point(21'(hex_acc));
          scan = SCAN_TEXT;
        end
      end
      SCAN_HELD: if (b == CH_BSLASH) begin
        scan = SCAN_HELD_BS;
      end else begin
        put_code_point(21'(high_half));
        high_half = '0;
        scan      = SCAN_TEXT;
        text_byte(b);
      end
      SCAN_HELD_BS: if (b == "u") begin
        scan    = SCAN_LOW_HEX;
        hex_acc = '0;
        hex_n   = '0;
      end else begin
        put_code_point(21'(high_half));
        high_half = '0;
        scan      = SCAN_ESC;
        escape_byte(b);
      end
      SCAN_LOW_HEX: if (hex_step(b)) begin
        if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
          abort_string(JSU_ERR_BAD_PAIR);
        end else begin
          cp = 21'h10000 + ((21'(high_half) - 21'hd800) << 10) + (21'(hex_acc) - 21'hdc00);
          put_code_point(cp);
          high_half = '0;
          scan      = SCAN_TEXT;
        end
      end
      default: begin
        go_idle();
        if (b == CH_QUOTE) scan = SCAN_TEXT;
        else abort_string(JSU_ERR_NO_QUOTE);
      end
    endcase
    // message ended inside the string: flush a held high half, then flag it
    if (is_end && scan != SCAN_IDLE) begin
      if (scan == SCAN_HELD || scan == SCAN_HELD_BS) put_code_point(21'(high_half));
      abort_string(JSU_ERR_UNTERMINATED);
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].run_end = 1'b1;
    foreach (run_q[i]) utf8_expect_q.insert(utf8_expect_q.size(), run_q[i]);
  endfunction

  task automatic check_result();
    unesc_result_t want;
    results_seen++;
    if (utf8_expect_q.size() == 0) begin
      report($sformatf("result %0d not expected: byte %02h status %0d code %0d last %0b",
                       results_seen, out_mon.out_byte, out_mon.status,
                       out_mon.error_code, out_mon.last_of_run));
      return;
    end
    want = utf8_expect_q.pop_front();
    if (out_mon.out_byte !== want.data)
      report($sformatf("result %0d: out_byte %02h, expected %02h",
                       results_seen, out_mon.out_byte, want.data));
    if (out_mon.status !== want.status)
      report($sformatf("result %0d: status %0d, expected %0d",
                       results_seen, out_mon.status, want.status));
    if (out_mon.error_code !== want.code)
      report($sformatf("result %0d: error_code %0d, expected %0d",
                       results_seen, out_mon.error_code, want.code));
    if (out_mon.last_of_run !== want.run_end)
      report($sformatf("result %0d: last_of_run %0b, expected %0b",
                       results_seen, out_mon.last_of_run, want.run_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      go_idle();
      utf8_expect_q.delete();
      swept = 1'b0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.in_byte, in_mon.is_last);
      if (out_mon.valid && out_mon.ready) check_result();
      if (drained && !swept) begin
        swept = 1'b1;
        while (utf8_expect_q.size() > 0) begin
          report($sformatf("result never came: byte %02h status %0d code %0d",
                           utf8_expect_q[0].data, utf8_expect_q[0].status,
                           utf8_expect_q[0].code));
          void'(utf8_expect_q.pop_front());
        end
      end
    end
    pending = utf8_expect_q.size();
  end

endmodule

// ----- tb/tb_json_string_unescape.sv -----
// top of the json string unescaper testbench: clock, reset, byte stimulus and result stalls
// depends on jsu_stream_if, json_string_unescape and jsu_result_checker
module tb_json_string_unescape;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    FLT_ESCAPE,
    FLT_HEX,
    FLT_PAIR,
    FLT_CONTROL,
    FLT_TRUNCATE,
    FLT_NO_QUOTE
  } fault_t;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_BYTES = 200;
  localparam int         HOLD_CYCLES  = 80;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BSLASH    = 8'h5c;
  localparam logic [7:0] CH_U         = 8'h75;

  logic       clk     = 1'b0;
  logic       rst_n   = 1'b0;
  logic       drained = 1'b0;
  int         errors;
  int         pending;
  bit         gaps_on  = 1'b1;
  bit         stall_on = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_left;
  int         bytes_sent;
  int         cycles;
  logic [7:0] msg[$];
  logic [7:0] esc_set[8]     = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};
  logic [7:0] bad_hex_set[8] = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hff};
  logic [15:0] bmp_codes[7]  = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800,
                                 16'hffff, 16'habcd};

  jsu_in_if  in_chan ();
  jsu_out_if out_chan ();

  json_string_unescape i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  jsu_result_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .drained (drained),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_json_string_unescape: errors");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_chan.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= !stall_on || ($urandom_range(99) >= 27);
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'h30 + d;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + d - 8'd10;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    msg.insert(msg.size(), b);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_digits(logic [15:0] v);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void add_hex4(logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_digits(v);
  endfunction

  function automatic void add_piece();
    int         sel;
    logic [7:0] b;
    logic [15:0] v;
    sel = $urandom_range(99);
    if (sel < 30) begin
      b = 8'($urandom_range(8'h7e, 8'h20));
      if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h61;
      add_byte(b);
    end else if (sel < 40) begin
      b = 8'($urandom_range(8'hff, 8'h80));
      add_byte(b);
    end else if (sel < 55) begin
      add_byte(CH_BSLASH);
      add_byte(esc_set[$urandom_range(7)]);
    end else if (sel < 67) begin
      case ($urandom_range(3))
        0: v = 16'($urandom_range(16'h7f));
        1: v = 16'($urandom_range(16'h7ff, 16'h80));
        2: v = 16'($urandom_range(16'hffff, 16'h800));
        default: v = 16'($urandom);
      endcase
      add_hex4(v);
    end else if (sel < 80) begin
      add_hex4(16'hd800 + 16'($urandom_range(16'h3ff)));
      add_hex4(16'hdc00 + 16'($urandom_range(16'h3ff)));
    end else if (sel < 88) begin
      add_hex4(16'hd800 + 16'($urandom_range(16'h3ff)));
    end else if (sel < 93) begin
      add_hex4(16'hdc00 + 16'($urandom_range(16'h3ff)));
    end else begin
      b = 8'($urandom);
      add_byte(b);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic is_end);
    while (gaps_on && $urandom_range(99) < 27) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    in_chan.is_last <= is_end;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg(input logic is_end);
    foreach (msg[i]) push_byte(msg[i], is_end && (i == msg.size() - 1));
    msg.delete();
  endtask

  task automatic random_msg();
    fault_t      kind;
    logic [7:0]  b;
    logic [15:0] v;
    logic        is_end;
    int          keep;
    is_end = ($urandom_range(3) != 0);
    add_byte(CH_QUOTE);
    if ($urandom_range(99) < 75) begin
      repeat ($urandom_range(6)) add_piece();
      add_byte(CH_QUOTE);
    end else begin
      kind = fault_t'($urandom_range(5));
      case (kind)
        FLT_ESCAPE: begin
          repeat ($urandom_range(3)) add_piece();
          b = 8'($urandom);
          foreach (esc_set[i]) if (b == esc_set[i]) b = 8'h78;
          if (b == CH_U) b = 8'h78;
          add_byte(CH_BSLASH);
          add_byte(b);
        end
        FLT_HEX: begin
          repeat ($urandom_range(3)) add_piece();
          add_byte(CH_BSLASH);
          add_byte(CH_U);
          repeat ($urandom_range(3)) add_byte(hex_char(4'($urandom)));
          add_byte(bad_hex_set[$urandom_range(7)]);
        end
        FLT_PAIR: begin
          repeat ($urandom_range(3)) add_piece();
          add_hex4(16'hd800 + 16'($urandom_range(16'h3ff)));
          v = 16'($urandom);
          if (v >= 16'hdc00 && v <= 16'hdfff) v = v ^ 16'h4000;
          add_byte(CH_BSLASH);
          add_byte(CH_U);
          add_digits(v);
        end
        FLT_CONTROL: begin
          repeat ($urandom_range(3)) add_piece();
          b = 8'($urandom_range(8'h1f));
          add_byte(b);
        end
        FLT_TRUNCATE: begin
          repeat ($urandom_range(6, 1)) add_piece();
          add_byte(CH_QUOTE);
          keep = $urandom_range(msg.size() - 1, 1);
          while (msg.size() > keep) msg.delete(msg.size() - 1);
          is_end = 1'b1;
        end
        default: begin
          msg.delete();
          b = 8'($urandom);
          if (b == CH_QUOTE) b = 8'h00;
          add_byte(b);
          repeat ($urandom_range(2)) begin
            b = 8'($urandom);
            add_byte(b);
          end
        end
      endcase
    end
    send_msg(is_end);
  endtask

  initial begin
    int rnd_start;
    int progress;
    bit held_once;
    bit paused_once;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = 8'h00;
    in_chan.is_last = 1'b0;
    bytes_sent  = 0;
    held_once   = 1'b0;
    paused_once = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed strings
    add_str("\"\"");
    send_msg(1'b1);
    add_str("\" a~");
    add_byte(8'h7f);
    add_byte(8'h80);
    add_byte(8'hff);
    add_str("\"");
    send_msg(1'b1);
    add_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    send_msg(1'b1);
    add_str("\"");
    foreach (bmp_codes[i]) add_hex4(bmp_codes[i]);
    add_str("\"");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd800);
    add_hex4(16'hdc00);
    add_hex4(16'hdbff);
    add_hex4(16'hdfff);
    add_str("\"");
    send_msg(1'b1);
    // high half followed by a plain char, an escape, the closing quote
    add_str("\"");
    add_hex4(16'hd83d);
    add_str("x\"");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd83d);
    add_str("\\n\"");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd83d);
    add_str("\"");
    send_msg(1'b0);
    add_str("\"");
    add_hex4(16'hdc00);
    add_str("\"");
    send_msg(1'b1);
    // broken pairs, escapes, hex digits and control bytes
    add_str("\"");
    add_hex4(16'hd800);
    add_hex4(16'h0041);
    add_str("\"");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd800);
    add_str("\\u00G");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd800);
    add_str("\\q");
    send_msg(1'b1);
    add_str("\"\\x");
    send_msg(1'b0);
    add_str("\"\\u12z4\"");
    send_msg(1'b1);
    add_str("\"a");
    add_byte(8'h1f);
    send_msg(1'b0);
    add_str("\"");
    add_byte(8'h00);
    send_msg(1'b0);
    // message ends in every part of the string
    add_str("\"abc");
    send_msg(1'b1);
    add_str("\"\\");
    send_msg(1'b1);
    add_str("\"\\u12");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd800);
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd800);
    add_str("\\");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hd800);
    add_str("\\uDC");
    send_msg(1'b1);
    add_str("\"");
    send_msg(1'b1);
    add_str("x");
    send_msg(1'b1);
    add_byte(8'hff);
    send_msg(1'b0);
    // five results from one byte, then strings back to back in one message
    add_str("\"");
    add_hex4(16'hd800);
    add_str("a");
    send_msg(1'b1);
    add_str("\"");
    add_hex4(16'hdbff);
    add_str("\\n");
    send_msg(1'b1);
    add_str("\"a\"\"b\"");
    send_msg(1'b1);

    // random strings
    rnd_start = bytes_sent;
    while (bytes_sent - rnd_start < RANDOM_BYTES) begin
      progress = bytes_sent - rnd_start;
      gaps_on  = !(progress >= 30 && progress < 100);
      stall_on = gaps_on;
      if (!held_once && progress >= 110) begin
        held_once = 1'b1;
        hold_req  = 1'b1;
      end
      if (!paused_once && progress >= 160) begin
        paused_once = 1'b1;
        in_chan.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      random_msg();
    end
    in_chan.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    drained <= 1'b1;
    repeat (3) @(negedge clk);
    if (errors == 0) begin
      $display("tb_json_string_unescape: clean");
    end else begin
      $display("tb_json_string_unescape: errors");
    end
    $finish;
  end

endmodule
